// ----- hw/rtl/usr_pkg.sv -----
// ----------------------------------------------------------------------------
// URL scheme recognizer package
// Shared constants, keyword tables and the result type for the scheme
// recognizer and its per-byte match logic.
// ----------------------------------------------------------------------------
`default_nettype none

package usr_pkg;

	// Number of keywords tracked by default.
	localparam int NUM_KEYWORDS_DEF = 10;

	// Size of the fixed keyword table and its longest entry.
	localparam int KW_TABLE_SIZE = 10;
	localparam int KW_MAX_LEN    = 6;

	// Widths of the stream payload fields.
	localparam int BYTE_W   = 8;
	localparam int CODE_W   = 4;
	localparam int OFFSET_W = 3;
	localparam int POS_W    = 3;

	// The scan position saturates here.
	localparam logic [POS_W-1:0] POS_MAX = 3'd7;

	// Result codes that do not come from the keyword table.
	localparam logic [CODE_W-1:0] CODE_MISSING = 4'd0;
	localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd1;

	// Characters with a special role in the scan.
	localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;

	// Keyword text, lower case, entry 0 first.
	localparam logic [0:KW_TABLE_SIZE-1][0:KW_MAX_LEN-1][BYTE_W-1:0] KW_TEXT = '{
		'{"h", "t", "t", "p", 8'h00, 8'h00},
		'{"g", "o", "p", "h", "e", "r"},
		'{"f", "t", "p", 8'h00, 8'h00, 8'h00},
		'{"l", "o", "c", "a", "l", 8'h00},
		'{"f", "i", "l", "e", 8'h00, 8'h00},
		'{"n", "n", "t", "p", 8'h00, 8'h00},
		'{"n", "e", "w", "s", 8'h00, 8'h00},
		'{"d", "a", "t", "a", 8'h00, 8'h00},
		'{"m", "a", "i", "l", "t", "o"},
		'{"h", "t", "t", "p", "s", 8'h00}
	};

	// Keyword lengths in bytes.
	localparam logic [0:KW_TABLE_SIZE-1][POS_W-1:0] KW_LEN = '{
		3'd4, 3'd6, 3'd3, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd5
	};

	// Scheme code reported for each keyword ('local' and 'file' share one).
	localparam logic [0:KW_TABLE_SIZE-1][CODE_W-1:0] KW_CODE = '{
		4'd2, 4'd3, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
	};

	// Result of processing one byte.
	typedef struct packed {
		logic                valid;
		logic [CODE_W-1:0]   code;
		logic [OFFSET_W-1:0] offset;
	} usr_result_t;

	// Character of keyword k at position pos, zero beyond the table row.
	function automatic logic [BYTE_W-1:0] kw_char(input int k, input logic [POS_W-1:0] pos);
		logic [BYTE_W-1:0] ch;
		ch = '0;
		if (int'(pos) < KW_MAX_LEN) begin
			ch = KW_TEXT[k][pos];
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/usr_step.sv -----
// ----------------------------------------------------------------------------
// URL scheme recognizer byte step
// Combinational logic for one byte: classifies the byte, compares it against
// all keywords in parallel and forms the next scan state and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module usr_step #(
	parameter int NUM_KEYWORDS = usr_pkg::NUM_KEYWORDS_DEF
) (
	input  wire logic [usr_pkg::BYTE_W-1:0] url_byte,
	input  wire logic                       start_req,
	input  wire logic [NUM_KEYWORDS-1:0]    live,
	input  wire logic [usr_pkg::POS_W-1:0]  pos,
	input  wire logic                       decided,
	output      logic [NUM_KEYWORDS-1:0]    live_next,
	output      logic [usr_pkg::POS_W-1:0]  pos_next,
	output      logic                       decided_next,
	output      usr_pkg::usr_result_t       result
);

	logic [NUM_KEYWORDS-1:0]                   live_eff;
	logic [usr_pkg::POS_W-1:0]                 pos_eff;
	logic                                      decided_eff;
	logic                                      is_scheme;
	logic [usr_pkg::BYTE_W-1:0]                lower;
	logic [NUM_KEYWORDS-1:0]                   keep;
	logic [NUM_KEYWORDS-1:0]                   hit;
	logic [NUM_KEYWORDS-1:0][usr_pkg::CODE_W-1:0] hit_code;

	// A start request clears the scan before the byte is looked at.
	always_comb begin
		live_eff    = start_req ? '1 : live;
		pos_eff     = start_req ? '0 : pos;
		decided_eff = start_req ? 1'b0 : decided;
	end

	// Byte class and case folding.
	always_comb begin
		is_scheme = ((url_byte >= "a") && (url_byte <= "z")) ||
			((url_byte >= "A") && (url_byte <= "Z")) ||
			((url_byte >= "0") && (url_byte <= "9")) ||
			(url_byte == usr_pkg::CHAR_DOT) || (url_byte == usr_pkg::CHAR_PLUS) ||
			(url_byte == usr_pkg::CHAR_MINUS);
		lower = url_byte;
		if ((url_byte >= "A") && (url_byte <= "Z")) begin
			lower = url_byte + 8'd32;
		end
	end

	// One comparator per keyword; entries past the table never match.
	for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
		if (k < usr_pkg::KW_TABLE_SIZE) begin : g_used
			assign keep[k] = live_eff[k] && (pos_eff < usr_pkg::KW_LEN[k]) &&
				(usr_pkg::kw_char(k, pos_eff) == lower);
			assign hit[k]      = live_eff[k] && (pos_eff == usr_pkg::KW_LEN[k]);
			assign hit_code[k] = usr_pkg::KW_CODE[k];
		end else begin : g_unused
			assign keep[k]     = 1'b0;
			assign hit[k]      = 1'b0;
			assign hit_code[k] = usr_pkg::CODE_UNKNOWN;
		end
	end

	// Next state and the result; the lowest matching keyword wins.
	always_comb begin
		live_next     = live_eff;
		pos_next      = pos_eff;
		decided_next  = decided_eff;
		result.valid  = 1'b0;
		result.code   = usr_pkg::CODE_MISSING;
		result.offset = '0;
		if (!decided_eff) begin
			if (is_scheme) begin
				live_next = keep;
				if (pos_eff < usr_pkg::POS_MAX) begin
					pos_next = pos_eff + 3'd1;
				end
			end else begin
				decided_next = 1'b1;
				result.valid = 1'b1;
				if (url_byte == usr_pkg::CHAR_COLON) begin
					result.code = usr_pkg::CODE_UNKNOWN;
					for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
						if (hit[k]) begin
							result.code   = hit_code[k];
							result.offset = pos_eff + 3'd1;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/url_scheme_recognizer.sv -----
// ----------------------------------------------------------------------------
// URL scheme recognizer
// Scans a URL one byte per transaction and reports the scheme code and the
// offset of the text after the colon at the first byte outside the scheme set.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register; its result is loaded
//   into the result register when the staged byte advances, which waits until
//   that register has room, and then leaves on the master side.
// Throughput: one byte per cycle while the result register has room; all keyword
//   compares run in parallel in the single logic stage between both registers.
// Reset: asynchronous; the block then ignores bytes until a start request.
// ----------------------------------------------------------------------------
`default_nettype none

module url_scheme_recognizer #(
	parameter int NUM_KEYWORDS = usr_pkg::NUM_KEYWORDS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output      logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] url_byte
	input  wire logic       s_axis_tuser,   // [0] start_req
	output      logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output      logic [7:0] m_axis_tdata    // [3:0] scheme_code, [6:4] rest_offset, [7] zero
);

	logic                              valid_s1;
	logic [usr_pkg::BYTE_W-1:0]        byte_s1;
	logic                              start_s1;
	logic                              advance;

	logic [NUM_KEYWORDS-1:0]           live_q;
	logic [usr_pkg::POS_W-1:0]         pos_q;
	logic                              decided_q;
	logic [NUM_KEYWORDS-1:0]           live_next;
	logic [usr_pkg::POS_W-1:0]         pos_next;
	logic                              decided_next;
	usr_pkg::usr_result_t              res;

	logic                              out_valid_q;
	logic [usr_pkg::CODE_W-1:0]        code_q;
	logic [usr_pkg::OFFSET_W-1:0]      offset_q;

	// The staged byte moves on whenever the result register has room.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Per-byte match logic.
	usr_step #(
		.NUM_KEYWORDS (NUM_KEYWORDS)
	) u_step (
		.url_byte     (byte_s1),
		.start_req    (start_s1),
		.live         (live_q),
		.pos          (pos_q),
		.decided      (decided_q),
		.live_next    (live_next),
		.pos_next     (pos_next),
		.decided_next (decided_next),
		.result       (res)
	);

	// Scan state, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '1;
			pos_q     <= '0;
			decided_q <= 1'b1;
		end else if (advance) begin
			live_q    <= live_next;
			pos_q     <= pos_next;
			decided_q <= decided_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && res.valid) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			code_q   <= res.code;
			offset_q <= res.offset;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, offset_q, code_q};

	// A result always leaves the scan in the decided state.
	a_result_decides : assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> decided_q)
		else $error("scan not decided after a result");

	// Without a start, a decided scan gives no result.
	a_quiet_when_decided : assert property (@(posedge clk) disable iff (!arst_n)
		advance && decided_q && !start_s1 |-> !res.valid)
		else $error("result given while decided");

	// A nonzero offset only comes with a keyword code.
	a_offset_with_match : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (offset_q != 3'd0) |->
			(code_q != usr_pkg::CODE_MISSING) && (code_q != usr_pkg::CODE_UNKNOWN))
		else $error("offset without a keyword match");

	// A keyword code always comes with its offset.
	a_match_has_offset : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (code_q != usr_pkg::CODE_MISSING) &&
			(code_q != usr_pkg::CODE_UNKNOWN) |-> (offset_q != 3'd0))
		else $error("keyword match without offset");

endmodule

`default_nettype wire

// ----- dv/url_scheme_recognizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL scheme recognizer testbench
// Streams URL bytes into the recognizer with random idle cycles on both
// sides. A scoreboard predicts the scheme code and rest offset for each
// accepted byte and checks every result transaction against the oldest
// prediction. Tests cover directed corner cases, a long sink stall, random
// well-formed URLs with mutations, and random byte noise.
// ----------------------------------------------------------------------------

module url_scheme_recognizer_tb;

	localparam int NUM_KW           = 10;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int MAX_GAP          = 18;
	localparam int MAX_PRINTS       = 50;

	// Scheme codes as they appear in the low nibble of the result.
	typedef enum logic [3:0] {
		SCH_MISSING,
		SCH_UNKNOWN,
		SCH_HTTP,
		SCH_GOPHER,
		SCH_FTP,
		SCH_LOCAL_FILE,
		SCH_NNTP,
		SCH_NEWS,
		SCH_DATA,
		SCH_MAILTO,
		SCH_HTTPS
	} scheme_t;

	typedef struct packed {
		logic [3:0] code;
		logic [2:0] offset;
	} scheme_result_t;

	// Scheme names in priority order and the code each one reports.
	string   scheme_names [NUM_KW] = '{"http", "gopher", "ftp", "local", "file",
		"nntp", "news", "data", "mailto", "https"};
	scheme_t scheme_codes [NUM_KW] = '{SCH_HTTP, SCH_GOPHER, SCH_FTP, SCH_LOCAL_FILE,
		SCH_LOCAL_FILE, SCH_NNTP, SCH_NEWS, SCH_DATA, SCH_MAILTO, SCH_HTTPS};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] url_byte
	logic       s_axis_tuser  = 1'b0;    // [0] start_req
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // [3:0] scheme_code, [6:4] rest_offset, [7] zero

	// Predictor state.
	logic [NUM_KW-1:0] live_names = '1;
	logic [2:0]        scan_pos   = 3'd0;
	bit                url_done   = 1'b1;

	scheme_result_t expected_schemes [$];
	int unsigned    mismatch_count   = 0;
	int unsigned    scanned_bytes    = 0;
	int unsigned    sink_holds_asked = 0;
	int unsigned    sink_holds_done  = 0;
	bit             tx_gaps_on       = 1'b1;
	bit             rx_gaps_on       = 1'b1;

	url_scheme_recognizer #(
		.NUM_KEYWORDS(NUM_KW)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Character classes used by both the predictor and the generators.
	function automatic bit is_scheme_char(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
			(b >= "0" && b <= "9") || b == usr_pkg::CHAR_DOT ||
			b == usr_pkg::CHAR_PLUS || b == usr_pkg::CHAR_MINUS;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		if (b >= "A" && b <= "Z") begin
			return b + 8'd32;
		end
		return b;
	endfunction

	// Advances the predictor by one accepted byte; flags a result when one is due.
	function automatic void predict_scheme(input logic [7:0] b, input logic start,
		output bit produced, output scheme_result_t res);
		logic [NUM_KW-1:0] keep;
		logic [7:0]        c;
		produced = 1'b0;
		res      = '0;
		if (start) begin
			live_names = '1;
			scan_pos   = 3'd0;
			url_done   = 1'b0;
		end
		if (url_done) begin
			return;
		end
		scanned_bytes++;
		// A scheme byte narrows the set of names still matching.
		if (is_scheme_char(b)) begin
			c    = to_lower(b);
			keep = '0;
			for (int k = 0; k < NUM_KW; k++) begin
				if (live_names[k] && int'(scan_pos) < scheme_names[k].len() &&
					scheme_names[k][scan_pos] == c) begin
					keep[k] = 1'b1;
				end
			end
			live_names = keep;
			if (scan_pos != 3'd7) begin
				scan_pos++;
			end
			return;
		end
		// Any other byte ends the scan with exactly one result.
		url_done  = 1'b1;
		produced  = 1'b1;
		res.code  = SCH_MISSING;
		if (b == usr_pkg::CHAR_COLON) begin
			res.code = SCH_UNKNOWN;
			for (int k = 0; k < NUM_KW; k++) begin
				if (live_names[k] && int'(scan_pos) == scheme_names[k].len()) begin
					res.code   = scheme_codes[k];
					res.offset = scan_pos + 3'd1;
					break;
				end
			end
		end
	endfunction

	function automatic int unsigned draw_gap();
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [7:0] rand_scheme_char();
		case ($urandom_range(0, 5))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return 8'("0" + $urandom_range(0, 9));
			3: return usr_pkg::CHAR_DOT;
			4: return usr_pkg::CHAR_PLUS;
			default: return usr_pkg::CHAR_MINUS;
		endcase
	endfunction

	function automatic logic [7:0] rand_terminator();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return usr_pkg::CHAR_COLON;
			2: return 8'($urandom_range(128, 255));
			default: begin
				do b = 8'($urandom); while (is_scheme_char(b));
				return b;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
	endtask

	// Offers one byte after a random gap and returns at the edge that accepts it.
	// Must be entered at a rising edge; tvalid stays high for back-to-back bytes.
	task automatic send_byte(input logic [7:0] b, input logic start);
		int unsigned gap;
		gap = tx_gaps_on ? draw_gap() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			s_axis_tuser  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == 0);
		end
	endtask

	// Stops offering bytes until every predicted result has arrived.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_schemes.size() != 0) @(posedge clk);
	endtask

	// Builds one URL: mostly scheme names with random case and mutations.
	task automatic send_random_url();
		logic [7:0]  text [$];
		logic [7:0]  ch;
		int unsigned kind;
		int unsigned k;
		int unsigned n;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			k = $urandom_range(0, NUM_KW - 1);
			for (int i = 0; i < scheme_names[k].len(); i++) begin
				ch = scheme_names[k][i];
				if ($urandom_range(0, 3) == 0) begin
					ch = ch - 8'd32;
				end
				text.push_back(ch);
			end
			// Near misses: shortened, extended, altered or prefixed names.
			case ($urandom_range(0, 9))
				0: void'(text.pop_back());
				1: text.push_back(rand_scheme_char());
				2: text[$urandom_range(0, text.size() - 1)] = rand_scheme_char();
				3: text.push_front(rand_scheme_char());
				default: ;
			endcase
			text.push_back(($urandom_range(0, 7) == 0) ? rand_terminator() :
				usr_pkg::CHAR_COLON);
		end else if (kind < 85) begin
			n = $urandom_range(0, 12);
			repeat (n) text.push_back(rand_scheme_char());
			text.push_back(($urandom_range(0, 1) == 0) ? usr_pkg::CHAR_COLON :
				rand_terminator());
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) text.push_back(8'($urandom));
		end
		// Trailing bytes are ignored once the result is out.
		n = $urandom_range(0, 3);
		repeat (n) text.push_back(8'($urandom));
		foreach (text[i]) begin
			send_byte(text[i], i == 0);
		end
	endtask

	task automatic test_directed_cases();
		// Bytes before any start are ignored.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// A colon or a terminator as the very first byte.
		send_byte(usr_pkg::CHAR_COLON, 1'b1);
		send_byte(8'h00, 1'b1);
		// Mixed case match, then bytes after the result are ignored.
		send_text("FtP:");
		send_byte("x", 1'b0);
		send_byte(usr_pkg::CHAR_COLON, 1'b0);
		// A high byte is not a scheme byte.
		send_byte("a", 1'b1);
		send_byte(8'h80, 1'b0);
		// A start in the middle of a scan restarts it.
		send_text("Ht");
		send_text("data:");
		send_text("file:");
	endtask

	// The sink holds off for a long stretch while the source keeps offering.
	task automatic test_sink_stall();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		sink_holds_asked++;
		repeat (12) send_byte(usr_pkg::CHAR_COLON, 1'b1);
		send_text("https:");
		send_text("gopher:");
		send_text("mailto:");
		send_text("local:");
		wait_for_results();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	task automatic test_random_urls();
		int unsigned url_count;
		url_count = 0;
		while (scanned_bytes < 900) begin
			// Every few dozen URLs pick a new pacing mode, sometimes after a drain.
			if (url_count % 40 == 0) begin
				if ($urandom_range(0, 2) == 0) begin
					wait_for_results();
				end
				tx_gaps_on = $urandom_range(0, 2) != 0;
				rx_gaps_on = $urandom_range(0, 2) != 0;
			end
			send_random_url();
			url_count++;
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	task automatic test_random_noise();
		repeat (150) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	// Sink pacing: a random stall after each result, plus requested long holds.
	initial begin : sink_pacing
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (sink_holds_asked != sink_holds_done) begin
				sink_holds_done++;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tready && m_axis_tvalid) begin
				stall_left = rx_gaps_on ? draw_gap() : 0;
				m_axis_tready <= (stall_left == 0);
			end else if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= (stall_left == 0);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Predicts on every input transaction and checks every result transaction.
	always @(posedge clk) begin : scoreboard
		bit             produced;
		scheme_result_t predicted;
		scheme_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_scheme(s_axis_tdata, s_axis_tuser, produced, predicted);
				if (produced) begin
					expected_schemes.push_back(predicted);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_schemes.size() == 0) begin
					report_mismatch($sformatf("result 0x%02h with none expected",
						m_axis_tdata));
				end else begin
					want = expected_schemes.pop_front();
					if (m_axis_tdata[3:0] !== want.code) begin
						report_mismatch($sformatf("scheme_code %0d, expected %0d",
							m_axis_tdata[3:0], want.code));
					end
					if (m_axis_tdata[6:4] !== want.offset) begin
						report_mismatch($sformatf("rest_offset %0d, expected %0d",
							m_axis_tdata[6:4], want.offset));
					end
					if (m_axis_tdata[7] !== 1'b0) begin
						report_mismatch("padding bit of result is not zero");
					end
				end
			end
		end
	end

	initial begin : main
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_sink_stall();
		test_random_urls();
		test_random_noise();
		wait_for_results();
		repeat (8) @(posedge clk);
		if (expected_schemes.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_schemes.size()));
		end
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#8000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
